// ----- rtl/core/sdspi_pkg.sv -----
package sdspi_pkg;

  localparam int BLOCK_BYTES_DEF = 512;
  localparam int LEN_W           = 10;
  localparam int FRAME_W         = 48;

  typedef enum logic [2:0] {
    MODE_CMD  = 3'd0,
    MODE_RD   = 3'd1,
    MODE_WR   = 3'd2,
    MODE_CARD = 3'd4
  } mode_t;

  typedef enum logic [12:0] {
    PH_IDLE   = 13'b0000000000001,
    PH_CPOLL  = 13'b0000000000010,
    PH_CFRAME = 13'b0000000000100,
    PH_CFILL  = 13'b0000000001000,
    PH_CRESP  = 13'b0000000010000,
    PH_RWAIT  = 13'b0000000100000,
    PH_RDATA  = 13'b0000001000000,
    PH_RCRC   = 13'b0000010000000,
    PH_WPOLL  = 13'b0000100000000,
    PH_WTOKEN = 13'b0001000000000,
    PH_WDATA  = 13'b0010000000000,
    PH_WCRC   = 13'b0100000000000,
    PH_WRESP  = 13'b1000000000000
  } phase_t;

  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] CMD_START   = 8'h40;
  localparam logic [7:0] CMD_STOP    = 8'd12;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] TOKEN_STOP  = 8'hFD;
  localparam logic [4:0] DRESP_OK    = 5'h05;
  localparam int         FRAME_BYTES = 6;

  typedef struct packed {
    logic [2:0]       mode;
    logic [7:0]       code;
    logic [31:0]      argument;
    logic [7:0]       crc_byte;
    logic [LEN_W-1:0] read_length;
    logic [7:0]       card_byte;
    logic [7:0]       write_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       chip_select;
    logic [7:0] rx_data;
    logic       rx_data_valid;
    logic       done_res;
    logic       status;
    logic [6:0] response;
  } res_t;

endpackage

// ----- rtl/core/sdspi_step.sv -----
module sdspi_step #(
  parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF,
  parameter int CNT_W       = sdspi_pkg::LEN_W
) (
  input  sdspi_pkg::item_t                   item,
  input  sdspi_pkg::phase_t                  phase_r,
  input  logic [CNT_W-1:0]                   cnt_r,
  input  logic [sdspi_pkg::FRAME_W-1:0]      frame_r,
  input  logic                               stop_r,
  input  logic [sdspi_pkg::LEN_W-1:0]        pend_r,
  input  logic [7:0]                         token_r,
  output sdspi_pkg::phase_t                  phase_nxt,
  output logic [CNT_W-1:0]                   cnt_nxt,
  output logic [sdspi_pkg::FRAME_W-1:0]      frame_nxt,
  output logic                               stop_nxt,
  output logic [sdspi_pkg::LEN_W-1:0]        pend_nxt,
  output logic [7:0]                         token_nxt,
  output sdspi_pkg::res_t                    res
);

  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       cb;

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign cb      = item.card_byte;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    frame_nxt = frame_r;
    stop_nxt  = stop_r;
    pend_nxt  = pend_r;
    token_nxt = token_r;
    res       = '0;
    res.tx_byte     = sdspi_pkg::BYTE_IDLE;
    res.chip_select = (phase_r != sdspi_pkg::PH_IDLE);

    unique case (item.mode)
      sdspi_pkg::MODE_CMD: begin
        frame_nxt = {item.code | sdspi_pkg::CMD_START, item.argument, item.crc_byte};
        stop_nxt  = (item.code == sdspi_pkg::CMD_STOP);
        cnt_nxt   = '0;
        phase_nxt = sdspi_pkg::PH_CPOLL;
        res.chip_select = 1'b1;
      end
      sdspi_pkg::MODE_RD: begin
        pend_nxt  = item.read_length;
        cnt_nxt   = '0;
        phase_nxt = sdspi_pkg::PH_RWAIT;
        res.chip_select = 1'b1;
      end
      sdspi_pkg::MODE_WR: begin
        token_nxt = item.code;
        cnt_nxt   = '0;
        phase_nxt = sdspi_pkg::PH_WPOLL;
        res.chip_select = 1'b1;
      end
      sdspi_pkg::MODE_CARD: begin
        unique case (phase_r)
          sdspi_pkg::PH_CPOLL: begin
            if (cb == sdspi_pkg::BYTE_IDLE) begin
              res.tx_byte = frame_r[47:40];
              frame_nxt   = {frame_r[39:0], 8'h00};
              cnt_nxt     = CNT_W'(1);
              phase_nxt   = sdspi_pkg::PH_CFRAME;
            end
          end
          sdspi_pkg::PH_CFRAME: begin
            if (cnt_r < CNT_W'(sdspi_pkg::FRAME_BYTES)) begin
              res.tx_byte = frame_r[47:40];
              frame_nxt   = {frame_r[39:0], 8'h00};
              cnt_nxt     = cnt_inc;
            end else begin
              phase_nxt = stop_r ? sdspi_pkg::PH_CFILL : sdspi_pkg::PH_CRESP;
            end
          end
          sdspi_pkg::PH_CFILL: begin
            phase_nxt = sdspi_pkg::PH_CRESP;
          end
          sdspi_pkg::PH_CRESP: begin
            if (!cb[7]) begin
              res.done_res = 1'b1;
              res.response = cb[6:0];
              phase_nxt    = sdspi_pkg::PH_IDLE;
            end
          end
          sdspi_pkg::PH_RWAIT: begin
            if (cb == sdspi_pkg::TOKEN_START) begin
              cnt_nxt   = '0;
              phase_nxt = (pend_r == '0) ? sdspi_pkg::PH_RCRC : sdspi_pkg::PH_RDATA;
            end
          end
          sdspi_pkg::PH_RDATA: begin
            res.rx_data       = cb;
            res.rx_data_valid = 1'b1;
            cnt_nxt           = cnt_inc;
            if (cnt_inc >= CNT_W'(pend_r)) begin
              cnt_nxt   = '0;
              phase_nxt = sdspi_pkg::PH_RCRC;
            end
          end
          sdspi_pkg::PH_RCRC: begin
            if (cnt_r == '0) begin
              cnt_nxt = CNT_W'(1);
            end else begin
              res.done_res = 1'b1;
              phase_nxt    = sdspi_pkg::PH_IDLE;
            end
          end
          sdspi_pkg::PH_WPOLL: begin
            if (cb == sdspi_pkg::BYTE_IDLE) begin
              res.tx_byte = token_r;
              phase_nxt   = sdspi_pkg::PH_WTOKEN;
            end
          end
          sdspi_pkg::PH_WTOKEN: begin
            if (token_r == sdspi_pkg::TOKEN_STOP) begin
              res.done_res = 1'b1;
              phase_nxt    = sdspi_pkg::PH_IDLE;
            end else begin
              res.tx_byte = item.write_byte;
              cnt_nxt     = CNT_W'(1);
              phase_nxt   = sdspi_pkg::PH_WDATA;
            end
          end
          sdspi_pkg::PH_WDATA: begin
            if (cnt_r < CNT_W'(BLOCK_BYTES)) begin
              res.tx_byte = item.write_byte;
              cnt_nxt     = cnt_inc;
            end else begin
              cnt_nxt   = '0;
              phase_nxt = sdspi_pkg::PH_WCRC;
            end
          end
          sdspi_pkg::PH_WCRC: begin
            if (cnt_r == '0) begin
              cnt_nxt = CNT_W'(1);
            end else begin
              phase_nxt = sdspi_pkg::PH_WRESP;
            end
          end
          sdspi_pkg::PH_WRESP: begin
            res.done_res = 1'b1;
            res.status   = (cb[4:0] != sdspi_pkg::DRESP_OK);
            phase_nxt    = sdspi_pkg::PH_IDLE;
          end
          default: begin
            phase_nxt       = sdspi_pkg::PH_IDLE;
            res.chip_select = 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/sd_spi_transfer_engine.sv -----
// Channel | Ports                                              | Direction
// in      | in_valid in_stall in_mode in_code in_argument      | request / card byte in
//         | in_crc_byte in_read_length in_card_byte in_write_byte |
// out     | out_valid out_stall out_tx_byte out_chip_select      | one result per transfer
//         | out_rx_data out_rx_data_valid out_done_res out_status out_response |
//
// One input transfer per cycle unless out_stall holds a valid result; one result per input transfer.
// Each transfer passes the input register and then the result register; the phase
// state updates as an item moves into the result register.
// Reset (rst_n low, synchronous) returns the engine to idle with empty stages.
// out_stall holds a valid result register and, while the input register is full, backs up into in_stall the same cycle.
module sd_spi_transfer_engine #(
  parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_mode,
  input  logic [7:0]                  in_code,
  input  logic [31:0]                 in_argument,
  input  logic [7:0]                  in_crc_byte,
  input  logic [sdspi_pkg::LEN_W-1:0] in_read_length,
  input  logic [7:0]                  in_card_byte,
  input  logic [7:0]                  in_write_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_tx_byte,
  output logic                        out_chip_select,
  output logic [7:0]                  out_rx_data,
  output logic                        out_rx_data_valid,
  output logic                        out_done_res,
  output logic                        out_status,
  output logic [6:0]                  out_response
);

  localparam int BB_W  = $clog2(BLOCK_BYTES + 1);
  localparam int CNT_W = (sdspi_pkg::LEN_W > BB_W) ? sdspi_pkg::LEN_W : BB_W;

  sdspi_pkg::item_t                 item_r;
  logic                             s1_v_r;
  sdspi_pkg::res_t                  res_r;
  sdspi_pkg::res_t                  res_nxt;
  logic                             out_v_r;
  logic                             adv;
  logic                             fire;

  sdspi_pkg::phase_t                phase_r, phase_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [sdspi_pkg::FRAME_W-1:0]    frame_r, frame_nxt;
  logic                             stop_r, stop_nxt;
  logic [sdspi_pkg::LEN_W-1:0]      pend_r, pend_nxt;
  logic [7:0]                       token_r, token_nxt;

  assign adv      = !out_v_r || !out_stall;
  assign fire     = s1_v_r && adv;
  assign in_stall = s1_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{mode: in_mode, code: in_code, argument: in_argument,
                  crc_byte: in_crc_byte, read_length: in_read_length,
                  card_byte: in_card_byte, write_byte: in_write_byte};
    end
  end

  sdspi_step #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .CNT_W       (CNT_W)
  ) u_step (
    .item      (item_r),
    .phase_r   (phase_r),
    .cnt_r     (cnt_r),
    .frame_r   (frame_r),
    .stop_r    (stop_r),
    .pend_r    (pend_r),
    .token_r   (token_r),
    .phase_nxt (phase_nxt),
    .cnt_nxt   (cnt_nxt),
    .frame_nxt (frame_nxt),
    .stop_nxt  (stop_nxt),
    .pend_nxt  (pend_nxt),
    .token_nxt (token_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdspi_pkg::PH_IDLE;
      cnt_r   <= '0;
      frame_r <= '0;
      stop_r  <= 1'b0;
      pend_r  <= '0;
      token_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      frame_r <= frame_nxt;
      stop_r  <= stop_nxt;
      pend_r  <= pend_nxt;
      token_r <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_tx_byte       = res_r.tx_byte;
  assign out_chip_select   = res_r.chip_select;
  assign out_rx_data       = res_r.rx_data;
  assign out_rx_data_valid = res_r.rx_data_valid;
  assign out_done_res      = res_r.done_res;
  assign out_status        = res_r.status;
  assign out_response      = res_r.response;

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("phase not one-hot");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_nxt.done_res |=> phase_r == sdspi_pkg::PH_IDLE)
    else $error("completed transfer did not return to idle");

  a_done_cs: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.done_res |-> res_r.chip_select)
    else $error("completion without chip select");

  a_rx_cs: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.rx_data_valid |-> res_r.chip_select && !res_r.done_res)
    else $error("read data outside an active read");

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item_r.mode == sdspi_pkg::MODE_CMD || item_r.mode == sdspi_pkg::MODE_RD ||
             item_r.mode == sdspi_pkg::MODE_WR) |=> phase_r != sdspi_pkg::PH_IDLE)
    else $error("request left engine idle");

endmodule

// ----- verif/sd_spi_transfer_engine_test.sv -----
module sd_spi_transfer_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK          = sdspi_pkg::BLOCK_BYTES_DEF;
  localparam int LEN_W        = sdspi_pkg::LEN_W;
  localparam int RANDOM_ITEMS = 1125;
  localparam int LONG_HOLD    = 80;
  localparam int LIMIT_CYCLES = 800000;

  localparam logic [2:0] MODE_RSV3 = 3'd3;
  localparam logic [2:0] MODE_RSV5 = 3'd5;
  localparam logic [2:0] MODE_RSV6 = 3'd6;
  localparam logic [2:0] MODE_RSV7 = 3'd7;
  localparam logic [2:0] RSV_MODES [4] = '{MODE_RSV3, MODE_RSV5, MODE_RSV6, MODE_RSV7};

  typedef enum logic [1:0] {PACE_FLAT, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  typedef struct packed {
    sdspi_pkg::item_t it;
    logic             typed;
    sdspi_pkg::res_t  want;
  } row_t;

  localparam sdspi_pkg::res_t NO_RES   = '0;
  localparam sdspi_pkg::res_t IDLE_RES =
    '{sdspi_pkg::BYTE_IDLE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 7'h00};
  localparam sdspi_pkg::res_t BUSY_RES =
    '{sdspi_pkg::BYTE_IDLE, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 7'h00};
  localparam sdspi_pkg::res_t DONE_RES =
    '{sdspi_pkg::BYTE_IDLE, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 7'h00};

  localparam row_t DIRECTED [25] = '{
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h5A, 8'h00}, 1'b1, IDLE_RES},
    '{'{MODE_RSV7, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 10'h3FF, 8'hFF, 8'hFF}, 1'b1, IDLE_RES},
    '{'{sdspi_pkg::MODE_CMD, sdspi_pkg::CMD_STOP, 32'hFFFF_FFFF, 8'h95, 10'd0, 8'h00, 8'h00},
      1'b1, BUSY_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'hFF, 32'h0000_0000, 8'h00, 10'd0, 8'h00, 8'hFF}, 1'b1, BUSY_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'hFF, 8'h00},
      1'b1, '{8'h4C, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 7'h00}},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h12, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h34, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h56, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h78, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'hFF, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h00, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h00, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h80, 8'h00}, 1'b0, NO_RES},
    '{'{MODE_RSV5, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h00, 8'h00}, 1'b1, BUSY_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h00, 8'h00}, 1'b1, DONE_RES},
    '{'{sdspi_pkg::MODE_RD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h00, 8'h00}, 1'b1, BUSY_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, sdspi_pkg::TOKEN_START,
        8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h3C, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'hC3, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_WR, sdspi_pkg::TOKEN_STOP, 32'h0000_0000, 8'h00, 10'd0, 8'h00, 8'h00},
      1'b1, BUSY_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'hFF, 8'h00},
      1'b1, '{sdspi_pkg::TOKEN_STOP, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 7'h00}},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h00, 8'hA5}, 1'b1, DONE_RES},
    '{'{sdspi_pkg::MODE_CMD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, 8'h00, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_RD, 8'hFF, 32'h0000_0000, 8'h00, 10'd520, 8'h00, 8'h00}, 1'b0, NO_RES},
    '{'{sdspi_pkg::MODE_CARD, 8'h00, 32'h0000_0000, 8'h00, 10'd0, sdspi_pkg::TOKEN_START,
        8'h00}, 1'b0, NO_RES}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           in_mode;
  logic [7:0]           in_code;
  logic [31:0]          in_argument;
  logic [7:0]           in_crc_byte;
  logic [LEN_W-1:0]     in_read_length;
  logic [7:0]           in_card_byte;
  logic [7:0]           in_write_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_tx_byte;
  logic                 out_chip_select;
  logic [7:0]           out_rx_data;
  logic                 out_rx_data_valid;
  logic                 out_done_res;
  logic                 out_status;
  logic [6:0]           out_response;

  sd_spi_transfer_engine #(.BLOCK_BYTES(BLK)) dut (.*);

  // engine state as seen by the byte predictor
  sdspi_pkg::phase_t             ph        = sdspi_pkg::PH_IDLE;
  logic [LEN_W-1:0]              cnt       = '0;
  logic [sdspi_pkg::FRAME_W-1:0] frame     = '0;
  logic                          stop_flag = 1'b0;
  logic [LEN_W-1:0]              pend_len  = '0;
  logic [7:0]                    tok       = '0;

  sdspi_pkg::res_t owed_bytes [$];
  pace_t pace          = PACE_FLAT;
  bit    full_write    = 1'b0;
  int    hold_requests = 0;
  int    cycles        = 0;
  int    n_bad         = 0;
  int    n_results     = 0;
  int    n_done        = 0;
  int    n_items       = 0;
  int    n_sent        = 0;
  int    n_cmd         = 0;
  int    n_rd          = 0;
  int    n_wr          = 0;

  function automatic bit coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [7:0] frame_byte(input int k);
    return frame[8*(sdspi_pkg::FRAME_BYTES-1-k) +: 8];
  endfunction

  function automatic sdspi_pkg::res_t engine_next(input sdspi_pkg::item_t it);
    sdspi_pkg::res_t r;
    r = '0;
    r.tx_byte = sdspi_pkg::BYTE_IDLE;
    r.chip_select = (ph != sdspi_pkg::PH_IDLE);
    unique case (it.mode)
      sdspi_pkg::MODE_CMD: begin
        frame = {it.code | sdspi_pkg::CMD_START, it.argument, it.crc_byte};
        stop_flag = (it.code == sdspi_pkg::CMD_STOP);
        cnt = '0;
        ph = sdspi_pkg::PH_CPOLL;
        r.chip_select = 1'b1;
      end
      sdspi_pkg::MODE_RD: begin
        pend_len = it.read_length;
        cnt = '0;
        ph = sdspi_pkg::PH_RWAIT;
        r.chip_select = 1'b1;
      end
      sdspi_pkg::MODE_WR: begin
        tok = it.code;
        cnt = '0;
        ph = sdspi_pkg::PH_WPOLL;
        r.chip_select = 1'b1;
      end
      sdspi_pkg::MODE_CARD: begin
        unique case (ph)
          sdspi_pkg::PH_CPOLL: if (it.card_byte == sdspi_pkg::BYTE_IDLE) begin
            r.tx_byte = frame_byte(0);
            cnt = LEN_W'(1);
            ph = sdspi_pkg::PH_CFRAME;
          end
          sdspi_pkg::PH_CFRAME: if (cnt < sdspi_pkg::FRAME_BYTES) begin
            r.tx_byte = frame_byte(int'(cnt));
            cnt++;
          end else begin
            ph = stop_flag ? sdspi_pkg::PH_CFILL : sdspi_pkg::PH_CRESP;
          end
          sdspi_pkg::PH_CFILL: ph = sdspi_pkg::PH_CRESP;
          sdspi_pkg::PH_CRESP: if (!it.card_byte[7]) begin
            r.done_res = 1'b1;
            r.response = it.card_byte[6:0];
            ph = sdspi_pkg::PH_IDLE;
          end
          sdspi_pkg::PH_RWAIT: if (it.card_byte == sdspi_pkg::TOKEN_START) begin
            cnt = '0;
            ph = (pend_len == 0) ? sdspi_pkg::PH_RCRC : sdspi_pkg::PH_RDATA;
          end
          sdspi_pkg::PH_RDATA: begin
            r.rx_data = it.card_byte;
            r.rx_data_valid = 1'b1;
            cnt++;
            if (cnt >= pend_len) begin
              cnt = '0;
              ph = sdspi_pkg::PH_RCRC;
            end
          end
          sdspi_pkg::PH_RCRC: if (cnt == 0) begin
            cnt = LEN_W'(1);
          end else begin
            r.done_res = 1'b1;
            ph = sdspi_pkg::PH_IDLE;
          end
          sdspi_pkg::PH_WPOLL: if (it.card_byte == sdspi_pkg::BYTE_IDLE) begin
            r.tx_byte = tok;
            ph = sdspi_pkg::PH_WTOKEN;
          end
          sdspi_pkg::PH_WTOKEN: if (tok == sdspi_pkg::TOKEN_STOP) begin
            r.done_res = 1'b1;
            ph = sdspi_pkg::PH_IDLE;
          end else begin
            r.tx_byte = it.write_byte;
            cnt = LEN_W'(1);
            ph = sdspi_pkg::PH_WDATA;
          end
          sdspi_pkg::PH_WDATA: if (cnt < BLK) begin
            r.tx_byte = it.write_byte;
            cnt++;
          end else begin
            cnt = '0;
            ph = sdspi_pkg::PH_WCRC;
          end
          sdspi_pkg::PH_WCRC: if (cnt == 0) begin
            cnt = LEN_W'(1);
          end else begin
            ph = sdspi_pkg::PH_WRESP;
          end
          sdspi_pkg::PH_WRESP: begin
            r.done_res = 1'b1;
            r.status = (it.card_byte[4:0] != sdspi_pkg::DRESP_OK);
            ph = sdspi_pkg::PH_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit sender_gap();
    unique case (pace)
      PACE_SEND: return coin(87);
      PACE_BOTH: return coin(27);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    unique case (pace)
      PACE_RECV: return coin(87);
      PACE_BOTH: return coin(27);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic sdspi_pkg::item_t random_item();
    sdspi_pkg::item_t it;
    it.mode        = 3'($urandom);
    it.code        = 8'($urandom);
    it.argument    = $urandom;
    it.crc_byte    = 8'($urandom);
    it.read_length = LEN_W'($urandom);
    it.card_byte   = 8'($urandom);
    it.write_byte  = 8'($urandom);
    return it;
  endfunction

  // card byte biased toward moving the current phase along
  function automatic logic [7:0] card_for_phase();
    logic [7:0] b;
    b = 8'($urandom);
    unique case (ph)
      sdspi_pkg::PH_CPOLL, sdspi_pkg::PH_WPOLL: if (coin(67)) b = sdspi_pkg::BYTE_IDLE;
      sdspi_pkg::PH_CRESP: if (coin(50)) b[7] = 1'b0;
      sdspi_pkg::PH_RWAIT: if (coin(50)) b = sdspi_pkg::TOKEN_START;
      sdspi_pkg::PH_WRESP: if (coin(75)) b[4:0] = sdspi_pkg::DRESP_OK;
      default: ;
    endcase
    return b;
  endfunction

  function automatic bit abandon_now();
    if (ph == sdspi_pkg::PH_WDATA) return full_write ? 1'b0 : coin(6);
    if (ph == sdspi_pkg::PH_RDATA && pend_len > 64) return 1'b0;
    return coin(2);
  endfunction

  task automatic build_request(inout sdspi_pkg::item_t it, input bit force_wr);
    int k;
    k = force_wr ? 9 : int'($urandom_range(0, 9));
    if (k < 5) begin
      it.mode = sdspi_pkg::MODE_CMD;
      if (coin(25)) it.code = sdspi_pkg::CMD_STOP;
    end else if (k < 8) begin
      it.mode = sdspi_pkg::MODE_RD;
      if (!coin(6)) it.read_length = LEN_W'($urandom_range(0, 8));
    end else begin
      it.mode = sdspi_pkg::MODE_WR;
      full_write = force_wr || coin(6);
      if (force_wr) it.code = 8'($urandom_range(0, 8'hFC));
      else if (coin(25)) it.code = sdspi_pkg::TOKEN_STOP;
    end
  endtask

  task automatic push_item(input sdspi_pkg::item_t it, input bit typed,
                           input sdspi_pkg::res_t want);
    sdspi_pkg::res_t pred;
    while (sender_gap()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_mode        <= it.mode;
    in_code        <= it.code;
    in_argument    <= it.argument;
    in_crc_byte    <= it.crc_byte;
    in_read_length <= it.read_length;
    in_card_byte   <= it.card_byte;
    in_write_byte  <= it.write_byte;
    do @(posedge clk); while (in_stall !== 1'b0);
    n_sent++;
    unique case (it.mode)
      sdspi_pkg::MODE_CMD:  begin n_cmd++; n_items++; end
      sdspi_pkg::MODE_RD:   begin n_rd++;  n_items++; end
      sdspi_pkg::MODE_WR:   begin n_wr++;  n_items++; end
      sdspi_pkg::MODE_CARD: if (ph != sdspi_pkg::PH_IDLE) n_items++;
      default: ;
    endcase
    pred = engine_next(it);
    owed_bytes.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      n_bad++;
      if (n_bad <= 10)
        $display("result %0d: %s expected %h, got %h", n_results, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, owed_bytes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    sdspi_pkg::res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (owed_bytes.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("result %0d with no transfer owed", n_results);
      end else begin
        want = owed_bytes.pop_front();
        check_field("tx_byte", want.tx_byte, out_tx_byte);
        check_field("chip_select", 8'(want.chip_select), 8'(out_chip_select));
        check_field("rx_data", want.rx_data, out_rx_data);
        check_field("rx_data_valid", 8'(want.rx_data_valid), 8'(out_rx_data_valid));
        check_field("done_res", 8'(want.done_res), 8'(out_done_res));
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("response", 8'(want.response), 8'(out_response));
        if (want.done_res) n_done++;
      end
      n_results++;
    end
  end

  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= receiver_stall();
      end
    end
  end

  initial begin : stimulus
    sdspi_pkg::item_t it;
    int    base;
    int    quarter;
    bit    first_req;
    bit    held;
    bit    drained;
    in_valid       = 1'b0;
    in_mode        = sdspi_pkg::MODE_CARD;
    in_code        = '0;
    in_argument    = '0;
    in_crc_byte    = '0;
    in_read_length = '0;
    in_card_byte   = '0;
    in_write_byte  = '0;
    rst_n          = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) push_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].want);

    base = n_items;
    first_req = 1'b1;
    held = 1'b0;
    drained = 1'b0;
    while (n_items - base < RANDOM_ITEMS || ph != sdspi_pkg::PH_IDLE) begin
      quarter = (n_items - base) * 4 / RANDOM_ITEMS;
      if (!held && n_items - base >= RANDOM_ITEMS / 8) begin
        held = 1'b1;
        hold_requests++;
      end
      if (!drained && quarter >= 2) begin
        drained = 1'b1;
        wait_drained();
      end
      unique case (quarter)
        0:       pace = PACE_FLAT;
        1:       pace = PACE_SEND;
        2:       pace = PACE_RECV;
        default: pace = PACE_BOTH;
      endcase
      it = random_item();
      if (coin(3)) begin
        it.mode = RSV_MODES[$urandom_range(0, 3)];
      end else if (ph == sdspi_pkg::PH_IDLE ? coin(92) : abandon_now()) begin
        build_request(it, first_req);
        first_req = 1'b0;
      end else begin
        it.mode = sdspi_pkg::MODE_CARD;
        it.card_byte = card_for_phase();
      end
      push_item(it, 1'b0, NO_RES);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    pace = PACE_FLAT;
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d transfers in (%0d acted on), %0d results checked, %0d completions",
             n_sent, n_items, n_results, n_done);
    $display("requests: %0d command, %0d read, %0d write; block held off once, drained once",
             n_cmd, n_rd, n_wr);
    if (n_bad == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
